### src/xor_prefix_bucket_route_table_assert.svh
// ---------------------------------------------------------------------------
// xor_prefix_bucket_route_table_assert.svh
// Assertion macros shared by the routing table RTL. Expect clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef XOR_PREFIX_BUCKET_ROUTE_TABLE_ASSERT_SVH
`define XOR_PREFIX_BUCKET_ROUTE_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define XPBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define XPBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/xpbr_pkg.sv
// ---------------------------------------------------------------------------
// xpbr_pkg
// Types, codes and helpers for the prefix-bucket routing table.
// ---------------------------------------------------------------------------
package xpbr_pkg;

  localparam int BUCKETS     = 8;
  localparam int DEPTH       = 8;
  localparam int ID_BITS     = 64;
  localparam int HANDLE_BITS = 16;

  localparam int NSLOTS  = BUCKETS * DEPTH;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int ADDR_W  = BKT_W + SLOT_W;
  localparam int PFX_W   = $clog2(ID_BITS + 1);
  localparam int CHUNKS  = (ID_BITS + 7) / 8;
  localparam int STEP_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_INS_ERR  = 2'd1;
  localparam logic [1:0] ST_ENTRY    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [63:0] node_id;
    logic [63:0] arrival_time;
    logic [15:0] node_handle;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] entry_id;
    logic [15:0] entry_handle;
    logic [63:0] entry_time;
    logic [2:0]  bucket_index;
    logic [2:0]  slot_index;
    logic        last;
  } result_t;

  // Classified command passed from front to back
  typedef struct packed {
    logic                   mode;
    logic [ID_BITS-1:0]     id;
    logic [63:0]            tstamp;
    logic [HANDLE_BITS-1:0] handle;
    logic [BKT_W-1:0]       bucket;
    logic                   full;
  } cmd_t;

  // One stored slot
  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic [63:0]            tstamp;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Leading zero count of one byte (8 when zero)
  function automatic logic [3:0] lzc8(input logic [7:0] v);
    logic [3:0] n;
    logic       hit;
    n   = 4'd8;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 4'(7 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Scale shared prefix length to a bucket, clamped to the last one
  function automatic logic [BKT_W-1:0] bucket_of(input logic [PFX_W-1:0] p);
    int b;
    b = (int'(p) * BUCKETS) / ID_BITS;
    if (b >= BUCKETS) begin
      b = BUCKETS - 1;
    end
    return BKT_W'(b);
  endfunction

endpackage

### src/xor_prefix_bucket_route_table.sv
// The front examines one id byte per cycle until a byte differs or the last byte
// is reached, then pushes once the queue has room; the back inserts into a bucket
// with a free slot at dispatch, else scans it (twice for a fully shared id that misses).
// A listing lookup strobes one result per valid slot, at most one per cycle.
// Sustained rate is set by the back's one-slot-per-cycle store read.
// Synchronous reset empties the table at once (valid bits) and clears local_node_id.
// ---------------------------------------------------------------------------
// xor_prefix_bucket_route_table
// Prefix-bucket routing table: the front classifies each word by the shared
// id prefix, a short queue decouples it from the back, which scans the store.
// ---------------------------------------------------------------------------
module xor_prefix_bucket_route_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  xpbr_pkg::item_t   item,
  output logic              busy,
  input  logic              cfg_wr_en,
  input  logic [63:0]       cfg_wr_data,
  output logic              result_valid,
  output xpbr_pkg::result_t result
);
  import xpbr_pkg::*;

`include "xor_prefix_bucket_route_table_assert.svh"

  // Local node id; the user must write it only while the table is idle, unchecked by the block
  logic [63:0] local_node_id;

  logic    push;
  cmd_t    push_data;
  logic    pop;
  cmd_t    head;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_node_id <= '0;
    end else if (cfg_wr_en) begin
      local_node_id <= cfg_wr_data;
    end
  end

  // Front: take one word, count the prefix shared with the local id, pick a bucket
  xpbr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .local_id  (local_node_id),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  // Queue: hold classified commands while the back is still scanning
  xpbr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back: insert into the first free or oldest slot, or list / match a bucket
  xpbr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  // An accepted word keeps the front busy in the next cycle
  `XPBR_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "front not busy after accept")
  // Only a lookup listing produces results that are not last
  `XPBR_ASSERT_NOW(a_nonlast_is_entry, result_valid && !result.last, result.status == ST_ENTRY, "non-last result is not an entry")
  // An insert error carries no slot and no handle
  `XPBR_ASSERT_NOW(a_err_clean, result_valid && (result.status == ST_INS_ERR), (result.slot_index == 3'd0) && (result.entry_handle == 16'd0), "insert error with payload")
  // A configuration write lands in the local id register
  `XPBR_ASSERT_NEXT(a_cfg_write, cfg_wr_en, local_node_id == $past(cfg_wr_data), "local id not written")

endmodule

### src/xpbr_ram.sv
// ---------------------------------------------------------------------------
// xpbr_ram
// Simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module xpbr_ram #(
  parameter int WIDTH = 8,
  parameter int WORDS = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/xpbr_front.sv
// ---------------------------------------------------------------------------
// xpbr_front
// Accept a word, count the shared id prefix a byte per cycle, pick a bucket.
// ---------------------------------------------------------------------------
module xpbr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  xpbr_pkg::item_t item,
  input  logic [63:0]     local_id,
  input  xpbr_pkg::q_stat_t q_stat,
  output logic            busy,
  output logic            push,
  output xpbr_pkg::cmd_t  push_data
);
  import xpbr_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_COUNT, F_PUSH} f_state_t;

  f_state_t           state;
  logic [ID_BITS-1:0] diff;
  logic [PFX_W-1:0]   prefix;
  logic [STEP_W-1:0]  step;
  cmd_t               cmd;
  logic [7:0]         top8;

  assign top8      = diff[ID_BITS-1 -: 8];
  assign busy      = (state != F_IDLE);
  assign push      = (state == F_PUSH) && !q_stat.full;
  assign push_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            diff       <= ID_BITS'(item.node_id ^ local_id);
            prefix     <= '0;
            step       <= '0;
            cmd.mode   <= item.mode;
            cmd.id     <= ID_BITS'(item.node_id);
            cmd.tstamp <= item.arrival_time;
            cmd.handle <= HANDLE_BITS'(item.node_handle);
            state      <= F_COUNT;
          end
        end
        F_COUNT: begin
          if (top8 != 8'd0) begin
            cmd.bucket <= bucket_of(prefix + PFX_W'(lzc8(top8)));
            cmd.full   <= 1'b0;
            state      <= F_PUSH;
          end else if (step == STEP_W'(CHUNKS - 1)) begin
            cmd.bucket <= bucket_of(PFX_W'(ID_BITS));
            cmd.full   <= 1'b1;
            state      <= F_PUSH;
          end else begin
            step   <= step + STEP_W'(1);
            prefix <= prefix + PFX_W'(8);
            diff   <= diff << 8;
          end
        end
        F_PUSH: begin
          if (push) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

### src/xpbr_queue.sv
// ---------------------------------------------------------------------------
// xpbr_queue
// Two-entry command queue between the front and back sections.
// ---------------------------------------------------------------------------
module xpbr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xpbr_pkg::cmd_t    push_data,
  input  logic              pop,
  output xpbr_pkg::cmd_t    head,
  output xpbr_pkg::q_stat_t q_stat
);
  import xpbr_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### src/xpbr_back.sv
// ---------------------------------------------------------------------------
// xpbr_back
// Carry out insert and lookup commands against the slot store.
// ---------------------------------------------------------------------------
module xpbr_back (
  input  logic              clk,
  input  logic              rst,
  input  xpbr_pkg::cmd_t    head,
  input  xpbr_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              result_valid,
  output xpbr_pkg::result_t result
);
  import xpbr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_MATCH, S_LIST, S_AGE} state_t;

  state_t            state;
  cmd_t              cmd;
  logic [NSLOTS-1:0] valid;
  logic [SLOT_W:0]   idx;
  logic              rd_pend;
  logic [SLOT_W-1:0] rd_slot;
  logic [63:0]       best;
  logic [SLOT_W-1:0] tgt;
  logic              found;

  logic [DEPTH-1:0]  vmask;
  logic              has_empty;
  logic [SLOT_W-1:0] first_empty;
  logic              later_any;
  logic              scanning;
  logic              issue;
  entry_t            rdat;
  logic              m_hit;
  logic              scan_end;
  logic              age_less;
  logic [SLOT_W-1:0] tgt_fin;
  logic              found_fin;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  entry_t            wdat;

  function automatic result_t mk(input logic [1:0] st, input logic [63:0] id,
                                 input logic [15:0] h, input logic [63:0] t,
                                 input logic [BKT_W-1:0] bk,
                                 input logic [SLOT_W-1:0] sl, input logic lst);
    result_t r;
    r.status       = st;
    r.entry_id     = id;
    r.entry_handle = h;
    r.entry_time   = t;
    r.bucket_index = 3'(bk);
    r.slot_index   = 3'(sl);
    r.last         = lst;
    return r;
  endfunction

  assign vmask     = valid[{cmd.bucket, SLOT_W'(0)} +: DEPTH];
  assign has_empty = ~&vmask;
  assign pop       = (state == S_IDLE) && !q_stat.empty;
  assign scanning  = (state == S_MATCH) || (state == S_LIST) || (state == S_AGE);
  assign issue     = scanning && (idx < (SLOT_W+1)'(DEPTH));

  always_comb begin
    first_empty = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (!vmask[j]) begin
        first_empty = SLOT_W'(j);
      end
    end
    later_any = 1'b0;
    for (int j = 0; j < DEPTH; j++) begin
      if ((j > int'(rd_slot)) && vmask[j]) begin
        later_any = 1'b1;
      end
    end
  end

  assign m_hit     = (state == S_MATCH) && rd_pend && vmask[rd_slot] && (rdat.id == cmd.id);
  assign scan_end  = rd_pend && (rd_slot == SLOT_W'(DEPTH - 1));
  assign age_less  = rd_pend && (rdat.tstamp < best);
  assign tgt_fin   = age_less ? rd_slot : tgt;
  assign found_fin = found || age_less;

  assign wr_en = ((state == S_DISPATCH) && (cmd.mode == MODE_INSERT) && has_empty) ||
                 ((state == S_AGE) && scan_end && found_fin);
  assign wr_slot     = (state == S_DISPATCH) ? first_empty : tgt_fin;
  assign wdat.id     = cmd.id;
  assign wdat.tstamp = cmd.tstamp;
  assign wdat.handle = cmd.handle;

  xpbr_ram #(
    .WIDTH (ENTRY_W),
    .WORDS (NSLOTS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({cmd.bucket, wr_slot}),
    .wdata (wdat),
    .re    (issue),
    .raddr ({cmd.bucket, idx[SLOT_W-1:0]}),
    .rdata (rdat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      result_valid <= 1'b0;
      idx          <= '0;
      rd_pend      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (wr_en) begin
        valid[{cmd.bucket, wr_slot}] <= 1'b1;
      end
      if (scanning) begin
        if (issue) begin
          idx     <= idx + (SLOT_W+1)'(1);
          rd_slot <= idx[SLOT_W-1:0];
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cmd   <= head;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx     <= '0;
          rd_pend <= 1'b0;
          best    <= ALL_ONES;
          tgt     <= '0;
          found   <= 1'b0;
          if (cmd.mode == MODE_INSERT) begin
            if (has_empty) begin
              result_valid <= 1'b1;
              result <= mk(ST_INSERTED, '0, 16'(cmd.handle), '0, cmd.bucket,
                           first_empty, 1'b1);
              state  <= S_IDLE;
            end else begin
              state <= S_AGE;
            end
          end else if (vmask == '0) begin
            result_valid <= 1'b1;
            result       <= mk(ST_EMPTY, '0, '0, '0, cmd.bucket, '0, 1'b1);
            state        <= S_IDLE;
          end else if (cmd.full) begin
            state <= S_MATCH;
          end else begin
            state <= S_LIST;
          end
        end
        S_MATCH: begin
          if (m_hit) begin
            result_valid <= 1'b1;
            result <= mk(ST_ENTRY, 64'(rdat.id), 16'(rdat.handle), rdat.tstamp,
                         cmd.bucket, rd_slot, 1'b1);
            state  <= S_IDLE;
          end else if (scan_end) begin
            // no exact hit: list the whole bucket from the first slot
            idx     <= '0;
            rd_pend <= 1'b0;
            state   <= S_LIST;
          end
        end
        S_LIST: begin
          if (rd_pend && vmask[rd_slot]) begin
            result_valid <= 1'b1;
            result <= mk(ST_ENTRY, 64'(rdat.id), 16'(rdat.handle), rdat.tstamp,
                         cmd.bucket, rd_slot, !later_any);
          end
          if (scan_end) begin
            state <= S_IDLE;
          end
        end
        S_AGE: begin
          if (age_less) begin
            best  <= rdat.tstamp;
            tgt   <= rd_slot;
            found <= 1'b1;
          end
          if (scan_end) begin
            result_valid <= 1'b1;
            if (found_fin) begin
              result <= mk(ST_INSERTED, '0, 16'(cmd.handle), '0, cmd.bucket,
                           tgt_fin, 1'b1);
            end else begin
              result <= mk(ST_INS_ERR, '0, '0, '0, cmd.bucket, '0, 1'b1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
